/* rtl/sbhq_pkg.sv */
// ----------------------------------------------------------------------------
// sbhq_pkg
// Types and codes shared by the heap queue modules.
// ----------------------------------------------------------------------------
package sbhq_pkg;

    localparam int KEY_W  = 15;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 3;
    localparam int POS_W  = 10;
    localparam int STAT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_EXTRACT = 3'd1,
        KIND_DELETE  = 3'd2,
        KIND_CLEAR   = 3'd3,
        KIND_FLIP    = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADPOS  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LAST,      // read last entry (extract)
        S_WR_HOLE,      // write last entry into hole
        S_UP_RD,        // read parent
        S_UP_CMP,       // compare and swap with parent
        S_DN_RD_L,      // read left child
        S_DN_RD_R,      // read right child, left data arrives
        S_DN_CMP,       // right data arrives, pick and swap
        S_FLIP_NEXT,    // start next rebuild node
        S_FLIP_RD,      // read rebuild node
        S_DONE
    } state_t;

endpackage

/* rtl/switchable_binary_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// switchable_binary_heap_queue_top
// Binary heap priority queue with switchable min/max order.
// ----------------------------------------------------------------------------
// Usage: present one operation on the s_ channel (kind, job_key, job_tag,
// position); each accepted transfer yields exactly one result on the m_
// channel (status, out_key, out_tag, count, max_first).
// Entries live in one single-port-style memory (one read or one write per
// cycle, read data registered); a sequencer reads, compares and writes back
// one heap level at a time, holding the current entry in a register.
// Flip rebuilds the heap bottom-up with count/2 sift-downs.
// One operation is in flight at a time; s_ready is low while it runs.
// The result sits in an output register: a stalled receiver holds it and
// the next transfer waits until it is taken.
// Reset empties the queue and selects min order; memory is not cleared.
// ----------------------------------------------------------------------------
module switchable_binary_heap_queue_top
    import sbhq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [KEY_W-1:0]    s_job_key,
    input  logic [TAG_W-1:0]    s_job_tag,
    input  logic [POS_W-1:0]    s_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [TAG_W-1:0]    m_out_tag,
    output logic [10:0]         m_count,
    output logic                m_max_first
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // heap memory
    entry_t mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    entry_t        mem_wdata;
    entry_t        mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else begin
            mem_rdata <= mem[mem_addr];
        end
    end

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          omax_reg, omax_next;
    logic [CW-1:0] idx_reg, idx_next;     // current hole position
    entry_t        cur_reg, cur_next;     // entry being sifted
    entry_t        lch_reg, lch_next;     // left child data
    logic [CW-1:0] flip_reg, flip_next;   // rebuild nodes remaining
    logic          inflip_reg, inflip_next;
    logic          ovalid_reg, ovalid_next;
    logic [STAT_W-1:0] ostat_reg, ostat_next;
    entry_t        oent_reg, oent_next;

    // ahead(a, b) in current order
    function automatic logic ahead(input logic omax, input entry_t a, input entry_t b);
        ahead = omax ? (a.key > b.key) : (a.key < b.key);
    endfunction

    logic [CW:0]   lidx, ridx;
    logic [CW-1:0] pidx;
    logic          take_in;
    logic          lch_ok, rch_ok;
    entry_t        best;
    logic [CW-1:0] best_idx;

    assign lidx   = {idx_reg, 1'b1};
    assign ridx   = {idx_reg, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
    assign pidx   = (idx_reg - {{(CW-1){1'b0}}, 1'b1}) >> 1;
    assign s_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign take_in = s_valid && s_ready;

    assign m_valid     = ovalid_reg;
    assign m_status    = ostat_reg;
    assign m_out_key   = oent_reg.key;
    assign m_out_tag   = oent_reg.tag;
    assign m_count     = 11'(cnt_reg);
    assign m_max_first = omax_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        omax_next   = omax_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        lch_next    = lch_reg;
        flip_next   = flip_reg;
        inflip_next = inflip_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        oent_next   = oent_reg;
        mem_we      = 1'b0;
        mem_addr    = idx_reg[AW-1:0];
        mem_wdata   = cur_reg;
        lch_ok      = 1'b0;
        rch_ok      = 1'b0;
        best        = cur_reg;
        best_idx    = idx_reg;

        if (ovalid_reg && m_ready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (take_in) begin
                    ostat_next  = ST_OK;
                    oent_next   = '0;
                    inflip_next = 1'b0;
                    state_next  = S_DONE;
                    case (s_kind)
                        KIND_INSERT: begin
                            if (cnt_reg >= CW'(DEPTH)) begin
                                ostat_next = ST_FULL;
                            end else begin
                                cur_next   = '{key: s_job_key, tag: s_job_tag};
                                idx_next   = cnt_reg;
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_UP_RD;
                            end
                        end
                        KIND_EXTRACT: begin
                            if (cnt_reg == '0) begin
                                ostat_next = ST_EMPTY;
                            end else begin
                                // read root first
                                mem_addr   = '0;
                                idx_next   = '0;
                                cnt_next   = cnt_reg - 1'b1;
                                state_next = S_RD_LAST;
                                ostat_next = ST_OK;
                                inflip_next = 1'b1; // marks extract: capture root
                            end
                        end
                        KIND_DELETE: begin
                            if (CW'(s_position) >= cnt_reg || (CW < POS_W &&
                                s_position >= POS_W'(DEPTH))) begin
                                ostat_next = ST_BADPOS;
                            end else begin
                                idx_next   = CW'(s_position);
                                cnt_next   = cnt_reg - 1'b1;
                                if (CW'(s_position) == cnt_reg - 1'b1) begin
                                    state_next = S_DONE;
                                end else begin
                                    mem_addr   = AW'(cnt_reg - 1'b1);
                                    state_next = S_WR_HOLE;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            cnt_next = '0;
                        end
                        KIND_FLIP: begin
                            omax_next = !omax_reg;
                            flip_next = cnt_reg >> 1;
                            state_next = S_FLIP_NEXT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_LAST: begin
                // root data arrives; read last entry
                oent_next   = mem_rdata;
                inflip_next = 1'b0;
                mem_addr    = AW'(cnt_reg);
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_WR_HOLE;
                end
            end
            S_WR_HOLE: begin
                // last entry arrives; it becomes the current entry at the hole
                cur_next = mem_rdata;
                mem_addr = idx_reg[AW-1:0];
                mem_we   = 1'b1;
                mem_wdata = mem_rdata;
                state_next = S_UP_RD;
            end
            S_UP_RD: begin
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_wdata  = cur_reg;
                    state_next = S_DN_RD_L;
                end else begin
                    mem_addr   = pidx[AW-1:0];
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (ahead(omax_reg, cur_reg, mem_rdata)) begin
                    // move parent down into the hole, climb
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    mem_addr   = idx_reg[AW-1:0];
                    idx_next   = pidx;
                    state_next = S_UP_RD;
                    inflip_next = 1'b1; // moved at least once
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = cur_reg;
                    mem_addr  = idx_reg[AW-1:0];
                    // if it never moved, it may need to go down (delete/extract)
                    state_next = inflip_reg ? S_DONE : S_DN_RD_L;
                    inflip_next = 1'b0;
                end
                if (idx_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DN_RD_L: begin
                inflip_next = 1'b0;
                if (lidx >= {1'b0, cnt_reg}) begin
                    mem_we    = 1'b1;
                    mem_wdata = cur_reg;
                    state_next = (flip_reg != '0) ? S_FLIP_NEXT : S_DONE;
                end else begin
                    mem_addr   = lidx[AW-1:0];
                    state_next = S_DN_RD_R;
                end
            end
            S_DN_RD_R: begin
                lch_next   = mem_rdata;
                mem_addr   = ridx[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                lch_ok = ahead(omax_reg, lch_reg, cur_reg);
                if (lch_ok) begin
                    best     = lch_reg;
                    best_idx = lidx[CW-1:0];
                end
                rch_ok = (ridx < {1'b0, cnt_reg}) && ahead(omax_reg, mem_rdata, best);
                if (rch_ok) begin
                    best     = mem_rdata;
                    best_idx = ridx[CW-1:0];
                end
                mem_we   = 1'b1;
                mem_addr = idx_reg[AW-1:0];
                if (lch_ok || rch_ok) begin
                    mem_wdata  = best;
                    idx_next   = best_idx;
                    state_next = S_DN_RD_L;
                end else begin
                    mem_wdata  = cur_reg;
                    state_next = (flip_reg != '0) ? S_FLIP_NEXT : S_DONE;
                end
            end
            S_FLIP_NEXT: begin
                if (flip_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = flip_reg - 1'b1;
                    mem_addr   = AW'(flip_reg - 1'b1);
                    flip_next  = flip_reg - 1'b1;
                    state_next = S_FLIP_RD;
                end
            end
            S_FLIP_RD: begin
                cur_next   = mem_rdata;
                state_next = (flip_reg == '0) ? S_DN_RD_L : S_DN_RD_L;
            end
            S_DONE: begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
                inflip_next = 1'b0;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            omax_reg   <= 1'b0;
            flip_reg   <= '0;
            inflip_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            omax_reg   <= omax_next;
            flip_reg   <= flip_next;
            inflip_reg <= inflip_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        lch_reg   <= lch_next;
        ostat_reg <= ostat_next;
        oent_reg  <= oent_next;
    end

endmodule

/* tb/switchable_binary_heap_queue_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switchable_binary_heap_queue_top_test
// Drives heap queue operations with random pacing, predicts each result with
// a private heap model and compares every result field by field.
// ----------------------------------------------------------------------------
module switchable_binary_heap_queue_top_test;
    import sbhq_pkg::*;

    localparam int QDEPTH = 1024;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  okey;
        logic [TAG_W-1:0]  otag;
        logic [10:0]       cnt;
        logic              maxf;
    } answer_t;

    int error_count = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    // heap model and queue of answers still owed by the block
    class heap_board;
        entry_t  slots [QDEPTH];
        int      fill;
        bit      maxo;
        answer_t owed [$];

        function bit ahead(entry_t a, entry_t b);
            return maxo ? (a.key > b.key) : (a.key < b.key);
        endfunction

        function void swap(int i, int j);
            entry_t t;
            t = slots[i];
            slots[i] = slots[j];
            slots[j] = t;
        endfunction

        function void sink(int i);
            int best;
            int l;
            forever begin
                best = i;
                l = 2 * i + 1;
                if (l < fill && ahead(slots[l], slots[best])) best = l;
                if (l + 1 < fill && ahead(slots[l + 1], slots[best])) best = l + 1;
                if (best == i) return;
                swap(i, best);
                i = best;
            end
        endfunction

        function void rise(int i);
            while (i > 0 && ahead(slots[i], slots[(i - 1) / 2])) begin
                swap(i, (i - 1) / 2);
                i = (i - 1) / 2;
            end
        endfunction

        function void note_op(logic [2:0] kind, logic [KEY_W-1:0] key,
                              logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
            answer_t a;
            a = '{ST_OK, 0, 0, 0, 0};
            case (kind)
                KIND_INSERT: begin
                    if (fill >= QDEPTH) a.status = ST_FULL;
                    else begin
                        slots[fill] = '{key, tag};
                        fill++;
                        rise(fill - 1);
                    end
                end
                KIND_EXTRACT: begin
                    if (fill == 0) a.status = ST_EMPTY;
                    else begin
                        a.okey = slots[0].key;
                        a.otag = slots[0].tag;
                        fill--;
                        slots[0] = slots[fill];
                        sink(0);
                    end
                end
                KIND_DELETE: begin
                    if (pos >= fill) a.status = ST_BADPOS;
                    else begin
                        fill--;
                        if (pos < fill) begin
                            slots[pos] = slots[fill];
                            if (pos > 0 && ahead(slots[pos], slots[(pos - 1) / 2]))
                                rise(pos);
                            else
                                sink(pos);
                        end
                    end
                end
                KIND_CLEAR: fill = 0;
                KIND_FLIP: begin
                    maxo = !maxo;
                    for (int i = fill / 2; i > 0; i--) sink(i - 1);
                end
                default: ;
            endcase
            a.cnt = 11'(fill);
            a.maxf = maxo;
            owed.push_back(a);
        endfunction

        task check(logic [STAT_W-1:0] st, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                   logic [10:0] c, logic mf);
            answer_t w;
            if (owed.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            w = owed.pop_front();
            if (st !== w.status) report("status", st, w.status);
            if (k !== w.okey) report("out_key", k, w.okey);
            if (t !== w.otag) report("out_tag", t, w.otag);
            if (c !== w.cnt) report("count", c, w.cnt);
            if (mf !== w.maxf) report("max_first", mf, w.maxf);
        endtask
    endclass

    heap_board board = new();

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_valid = 0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = 0;
    logic [KEY_W-1:0]    s_job_key = 0;
    logic [TAG_W-1:0]    s_job_tag = 0;
    logic [POS_W-1:0]    s_position = 0;
    logic                m_valid;
    logic                m_ready = 0;
    logic [STAT_W-1:0]   m_status;
    logic [KEY_W-1:0]    m_out_key;
    logic [TAG_W-1:0]    m_out_tag;
    logic [10:0]         m_count;
    logic                m_max_first;

    bit stim_done = 0;
    bit hold_off = 0;   // long receiver stall requested by the stimulus

    switchable_binary_heap_queue_top #(.DEPTH(QDEPTH)) i_dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // Note each input transfer and check each result transfer at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_op(s_kind, s_job_key, s_job_tag, s_position);
        if (aresetn && m_valid && m_ready)
            board.check(m_status, m_out_key, m_out_tag, m_count, m_max_first);
    end

    // Receiver: idle a random wait per result, honor the hold-off, then take one.
    initial begin
        int waitc;
        @(posedge aresetn);
        forever begin
            waitc = $urandom_range(0, 7);
            repeat (waitc) @(negedge aclk);
            while (hold_off) @(negedge aclk);
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            m_ready <= 0;
        end
    end

    // Offer one operation after a random gap (none with nogap) and hold it until the transfer.
    task automatic send(input logic [2:0] kind, input logic [KEY_W-1:0] key,
                        input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] pos,
                        input bit nogap = 0);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_kind <= kind;
        s_job_key <= key;
        s_job_tag <= tag;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic rand_op(input int fill_bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < fill_bias)
            send(KIND_INSERT, KEY_W'($urandom_range(0, 32767)), TAG_W'($urandom), 0);
        else if (r < fill_bias + 25)
            send(KIND_EXTRACT, KEY_W'($urandom), TAG_W'($urandom), POS_W'($urandom));
        else if (r < fill_bias + 38)
            // mostly in range, sometimes past the end
            send(KIND_DELETE, 0, 0, POS_W'(($urandom_range(0, 9) == 0) ? $urandom :
                 $urandom_range(0, board.fill)));
        else if (r < fill_bias + 41)
            send(KIND_FLIP, KEY_W'($urandom), TAG_W'($urandom), POS_W'($urandom));
        else if (r < fill_bias + 42)
            send(KIND_CLEAR, 0, 0, 0);
        else
            send(KIND_W'($urandom_range(5, 7)), KEY_W'($urandom), TAG_W'($urandom),
                 POS_W'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: empty cases, key extremes, every kind, unused kinds
        send(KIND_EXTRACT, 0, 0, 0);
        send(KIND_DELETE, 0, 0, 0);
        send(KIND_FLIP, 0, 0, 0);
        send(KIND_FLIP, 0, 0, 0);
        send(KIND_INSERT, 15'h7FFF, 16'hFFFF, 10'h3FF);
        send(KIND_INSERT, 0, 0, 0);
        send(KIND_INSERT, 100, 16'h1234, 0);
        send(KIND_INSERT, 100, 16'h5678, 0);
        send(KIND_DELETE, 0, 0, 10'h3FF);
        send(KIND_DELETE, 0, 0, 4);
        send(KIND_DELETE, 0, 0, 3);
        send(KIND_DELETE, 0, 0, 1);
        send(KIND_FLIP, 0, 0, 0);
        send(KIND_EXTRACT, 0, 0, 0);
        send(5, 15'h7FFF, 16'hFFFF, 10'h3FF);
        send(7, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0);
        send(KIND_EXTRACT, 0, 0, 0);

        // back-to-back inserts under a long receiver hold-off
        fork
            begin
                hold_off = 1;
                repeat (200) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 60; i++)
                send(KIND_INSERT, KEY_W'($urandom_range(0, 32767)), TAG_W'($urandom), 0, 1);
        join
        send(KIND_DELETE, 0, 0, 10'h3FF);
        send(KIND_FLIP, 0, 0, 0);
        repeat (10) send(KIND_EXTRACT, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0);

        // random: insert-heavy then drain-heavy phases
        for (int i = 0; i < 350; i++)
            rand_op((i % 150) < 90 ? 55 : 25);
        s_valid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("[switchable_binary_heap_queue_top] OK");
        else
            $display("[switchable_binary_heap_queue_top] ERROR");
        $finish;
    end

    initial begin
        #200ms;
        $display("[switchable_binary_heap_queue_top] ERROR");
        $finish;
    end

endmodule
